[rtl/hex_escape_codec_macros.svh]
// Assertion macros shared by the hex escape codec RTL.
`ifndef HEX_ESCAPE_CODEC_MACROS_SVH
`define HEX_ESCAPE_CODEC_MACROS_SVH

`ifndef SYNTH
// Whenever ante holds, cons must hold (cons may begin with a delay operator).
`define HEC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> cons) \
		else $error("hex_escape_codec: implication failed");
// The condition must never be seen true outside reset.
`define HEC_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("hex_escape_codec: forbidden condition seen");
`else
`define HEC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define HEC_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

[rtl/hec_pkg.sv]
// Types, character constants and helper functions of the hex escape codec.
`timescale 1ns / 1ps
`default_nettype none

package hec_pkg;

	localparam int CHAR_W = 16;
	localparam int DIG_W  = 3;
	localparam int CNT_W  = 3;

	localparam logic [CHAR_W-1:0] CHR_PCT   = 16'h0025;
	localparam logic [CHAR_W-1:0] CHR_SPACE = 16'h0020;
	localparam logic [CHAR_W-1:0] CHR_SLASH = 16'h002F;
	localparam logic [CHAR_W-1:0] CHR_BSL   = 16'h005C;
	localparam logic [CHAR_W-1:0] CHR_CR    = 16'h000D;
	localparam logic [CHAR_W-1:0] CHR_LF    = 16'h000A;
	localparam logic [CHAR_W-1:0] CHR_DOT   = 16'h002E;
	localparam logic [CHAR_W-1:0] CHR_DASH  = 16'h002D;
	localparam logic [CHAR_W-1:0] CHR_USCORE = 16'h005F;

	localparam logic [DIG_W-1:0] ESC_DIGITS = 3'd4;
	localparam logic [CNT_W-1:0] ESC_LEN    = 3'd5;

	typedef enum logic [1:0] {
		MODE_STRICT = 2'd0,
		MODE_PATH   = 2'd1,
		MODE_LINE   = 2'd2,
		MODE_DECODE = 2'd3
	} mode_t;

	// One result item
	typedef struct packed {
		logic [CHAR_W-1:0] chr;
		logic              chr_valid;
		logic              run_last;
		logic              str_end;
	} result_t;

	// Result count of the current item and the codec state it leaves
	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [DIG_W-1:0]  dp_nxt;
		logic [CHAR_W-1:0] acc_nxt;
	} plan_t;

	// Safe-character test of the three encode classes
	function automatic logic is_safe(input mode_t m, input logic [CHAR_W-1:0] c);
		logic s;
		case (m)
			MODE_STRICT: s = (c inside {[16'h0030:16'h0039], [16'h0061:16'h007A],
				[16'h0041:16'h005A]}) || c == CHR_DOT || c == CHR_DASH ||
				c == CHR_USCORE || c == CHR_SPACE;
			MODE_PATH:   s = c != CHR_PCT && c != CHR_SLASH && c != CHR_BSL;
			default:     s = c != CHR_PCT && c != CHR_CR && c != CHR_LF;
		endcase
		return s;
	endfunction

	// Hex digit value, zero for anything that is not a hex digit
	function automatic logic [3:0] hex_value(input logic [CHAR_W-1:0] c);
		logic [3:0] v;
		if (c inside {[16'h0030:16'h0039]})
			v = c[3:0];
		else if (c inside {[16'h0041:16'h0046], [16'h0061:16'h0066]})
			v = 4'(c[3:0] + 4'd9);
		else
			v = 4'd0;
		return v;
	endfunction

	// Uppercase hex character of one nibble
	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
		logic [CHAR_W-1:0] h;
		if (d < 4'd10)
			h = 16'h0030 + CHAR_W'(d);
		else
			h = 16'h0037 + CHAR_W'(d);
		return h;
	endfunction

endpackage

`default_nettype wire

[rtl/hec_step.sv]
// Per-item codec logic: result count, result at a given index, next state.
`timescale 1ns / 1ps
`default_nettype none

module hec_step (
	input  hec_pkg::mode_t                       mode,
	input  logic [hec_pkg::CHAR_W-1:0]           chr,
	input  logic                                 last,
	input  logic [hec_pkg::DIG_W-1:0]            dp,
	input  logic [hec_pkg::CHAR_W-1:0]           acc,
	input  logic [hec_pkg::CNT_W-1:0]            idx,
	output hec_pkg::plan_t                       plan,
	output hec_pkg::result_t                     res
);
	import hec_pkg::*;

	logic [CHAR_W-1:0] acc_sh;
	logic [CNT_W-1:0]  cnt;
	logic [CHAR_W-1:0] ch;
	logic              vld;

	always_comb begin
		acc_sh       = {acc[CHAR_W-5:0], hex_value(chr)};
		cnt          = '0;
		ch           = '0;
		vld          = 1'b1;
		plan.dp_nxt  = dp;
		plan.acc_nxt = acc;
		if (mode != MODE_DECODE) begin
			// encode: pass through or percent plus four digits
			plan.dp_nxt  = '0;
			plan.acc_nxt = '0;
			if (is_safe(mode, chr)) begin
				cnt = 3'd1;
				ch  = chr;
			end else begin
				cnt = ESC_LEN;
				case (idx)
					3'd1:    ch = hex_char(chr[15:12]);
					3'd2:    ch = hex_char(chr[11:8]);
					3'd3:    ch = hex_char(chr[7:4]);
					3'd4:    ch = hex_char(chr[3:0]);
					default: ch = CHR_PCT;
				endcase
			end
		end else if (dp != '0) begin
			// decode: gather one digit
			plan.acc_nxt = acc_sh;
			plan.dp_nxt  = dp - 3'd1;
			if (dp == 3'd1) begin
				cnt          = 3'd1;
				ch           = (acc_sh == '0) ? CHR_SPACE : acc_sh;
				plan.acc_nxt = '0;
			end
		end else if (chr == CHR_PCT) begin
			plan.dp_nxt  = ESC_DIGITS;
			plan.acc_nxt = '0;
		end else begin
			cnt = 3'd1;
			ch  = chr;
		end

		// end of string drops an open escape, marker if nothing else goes out
		if (last) begin
			plan.dp_nxt  = '0;
			plan.acc_nxt = '0;
			if (cnt == '0) begin
				cnt = 3'd1;
				ch  = '0;
				vld = 1'b0;
			end
		end

		plan.cnt      = cnt;
		res.chr       = ch;
		res.chr_valid = vld;
		res.run_last  = (idx == cnt - 3'd1);
		res.str_end   = (idx == cnt - 3'd1) && last;
	end

endmodule

`default_nettype wire

[rtl/hec_obuf.sv]
// Output register stage of the result stream.
`timescale 1ns / 1ps
`default_nettype none

module hec_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  hec_pkg::result_t res,
	output logic             free,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,  // [15:0] char_out
	output logic [1:0]       m_tuser,  // [0] char_valid, [1] run_last
	output logic             m_tlast   // string_end
);
	import hec_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || m_tready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = res_q.chr;
	assign m_tuser  = {res_q.run_last, res_q.chr_valid};
	assign m_tlast  = res_q.str_end;

endmodule

`default_nettype wire

[rtl/hex_escape_codec.sv]
// Top level of the hex escape codec: input register, sequencing, state, output.
// An accepted item passes the input register and then the output register before its first result.
// Items: one item per cycle when each item gives at most one result and the output is not stalled;
//   an escaped character in encode mode holds the input register until its five results are loaded.
// The output register sets the pace: one result leaves per cycle while m_tready is high.
// Reset (arst_n low, asynchronous): stages empty, mode strict encode, no escape open.
`timescale 1ns / 1ps
`default_nettype none
`include "hex_escape_codec_macros.svh"

module hex_escape_codec (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_wdata,  // mode
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] char_in
	input  logic        s_tlast,    // string_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [15:0] char_out
	output logic [1:0]  m_tuser,    // [0] char_valid, [1] run_last
	output logic        m_tlast     // string_end
);
	import hec_pkg::*;

	mode_t             mode_q;
	logic              s1_valid_q;
	logic [CHAR_W-1:0] chr_s1;
	logic              last_s1;
	logic [DIG_W-1:0]  dp_q;
	logic [CHAR_W-1:0] acc_q;
	logic [CNT_W-1:0]  idx_q;
	plan_t             plan;
	result_t           res;
	logic              out_free;
	logic              out_load;
	logic              item_done;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STRICT;
		end else if (cfg_wen) begin
			mode_q <= mode_t'(cfg_wdata);
		end
	end

	// item leaves the input stage as its last result is loaded, or without a load if it gives none
	assign out_load  = s1_valid_q && plan.cnt != '0 && out_free;
	assign item_done = s1_valid_q && (plan.cnt == '0 || (out_free && res.run_last));
	assign s_tready  = !s1_valid_q || item_done;

	// input stage control and codec state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			idx_q      <= '0;
			dp_q       <= '0;
			acc_q      <= '0;
		end else begin
			if (s_tready) begin
				s1_valid_q <= s_tvalid;
			end
			if (item_done) begin
				idx_q <= '0;
				dp_q  <= plan.dp_nxt;
				acc_q <= plan.acc_nxt;
			end else if (out_load) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// input payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			chr_s1  <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	hec_step u_step (
		.mode (mode_q),
		.chr  (chr_s1),
		.last (last_s1),
		.dp   (dp_q),
		.acc  (acc_q),
		.idx  (idx_q),
		.plan (plan),
		.res  (res)
	);

	hec_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// an item with results finishes only as its final result is loaded
	`HEC_ASSERT_IMPLIES(a_done_loads, clk, arst_n, item_done && plan.cnt != '0, out_load)
	// result index stays inside the current item's result count
	`HEC_ASSERT_IMPLIES(a_idx_range, clk, arst_n, s1_valid_q,
		(plan.cnt == '0 && idx_q == '0) || (plan.cnt != '0 && idx_q < plan.cnt))
	// never more digits pending than one escape holds
	`HEC_ASSERT_NEVER(a_dp_range, clk, arst_n, dp_q > ESC_DIGITS)
	// encode items and string ends leave no escape open
	`HEC_ASSERT_IMPLIES(a_state_clear, clk, arst_n,
		item_done && (mode_q != MODE_DECODE || last_s1), ##1 (dp_q == '0 && acc_q == '0))

endmodule

`default_nettype wire
